FILE: hdl/xoroshiro_random_generator_assert.svh
// Assertion macros for the xoroshiro random generator.
`ifndef XOROSHIRO_RANDOM_GENERATOR_ASSERT_SVH
`define XOROSHIRO_RANDOM_GENERATOR_ASSERT_SVH

// Implication into the next cycle.
`define XRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xrg assertion failed");

// Implication in the same cycle.
`define XRG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xrg assertion failed");

`endif

FILE: hdl/xrg_pkg.sv
`default_nettype none

package xrg_pkg;

   localparam int WordWidth   = 64;
   localparam int MantWidth   = 52;
   localparam int ExpWidth    = 11;
   localparam int JumpSteps   = 128;
   localparam int CountWidth  = $clog2(JumpSteps);
   localparam int ReqWidth    = 72;
   localparam int RotSum      = 17;
   localparam int RotZero     = 49;
   localparam int ShiftT      = 21;
   localparam int RotOne      = 28;

   localparam logic [JumpSteps-1:0] JumpMask =
      128'h170865df4b3201fc_df900294d8f554a5;
   localparam logic [ExpWidth-1:0]  ExpStart = 11'd1022;

   typedef enum logic [1:0] {
      OP_SEED   = 2'd0,
      OP_DRAW64 = 2'd1,
      OP_DRAW32 = 2'd2,
      OP_DOUBLE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_JUMP,
      ST_NORM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [MantWidth-1:0] mant;
   } norm_ctl_type;

   typedef struct packed {
      logic                 done;
      logic [WordWidth-1:0] bits;
   } norm_rsp_type;

endpackage

`default_nettype wire

FILE: hdl/xrg_step.sv
`default_nettype none

module xrg_step (
   input  wire  logic [xrg_pkg::WordWidth-1:0] word_zero,
   input  wire  logic [xrg_pkg::WordWidth-1:0] word_one,
   output logic       [xrg_pkg::WordWidth-1:0] next_zero,
   output logic       [xrg_pkg::WordWidth-1:0] next_one,
   output logic       [xrg_pkg::WordWidth-1:0] draw
);
   import xrg_pkg::*;

   logic [WordWidth-1:0] sum;
   logic [WordWidth-1:0] t;

   always_comb begin
      sum       = word_zero + word_one;
      draw      = {sum[WordWidth-RotSum-1:0], sum[WordWidth-1:WordWidth-RotSum]} + word_zero;
      t         = word_one ^ word_zero;
      next_zero = {word_zero[WordWidth-RotZero-1:0], word_zero[WordWidth-1:WordWidth-RotZero]}
                  ^ t ^ (t << ShiftT);
      next_one  = {t[WordWidth-RotOne-1:0], t[WordWidth-1:WordWidth-RotOne]};
   end

endmodule

`default_nettype wire

FILE: hdl/xrg_norm.sv
`default_nettype none

module xrg_norm (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  xrg_pkg::norm_ctl_type ctl,
   output xrg_pkg::norm_rsp_type       rsp
);
   import xrg_pkg::*;

   logic                 busy_ff, busy_in;
   logic [MantWidth-1:0] mant_ff, mant_in;
   logic [ExpWidth-1:0]  exp_ff,  exp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
   end

   // One leading-zero step per cycle: skip a byte of zeros or a single bit.
   always_comb begin
      busy_in  = busy_ff;
      mant_in  = mant_ff;
      exp_in   = exp_ff;
      rsp.done = 1'b0;
      rsp.bits = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         mant_in = ctl.mant;
         exp_in  = ExpStart;
      end else if (busy_ff) begin
         priority if (mant_ff == '0) begin
            rsp.done = 1'b1;
            busy_in  = 1'b0;
         end else if (mant_ff[MantWidth-1]) begin
            rsp.done = 1'b1;
            rsp.bits = {1'b0, exp_ff, mant_ff[MantWidth-2:0], 1'b0};
            busy_in  = 1'b0;
         end else if (mant_ff[MantWidth-1:MantWidth-8] == '0) begin
            mant_in = mant_ff << 8;
            exp_in  = exp_ff - ExpWidth'(8);
         end else begin
            mant_in = mant_ff << 1;
            exp_in  = exp_ff - ExpWidth'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/xoroshiro_random_generator.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: operation[1:0], seed_value[65:2]
// rsp     | out | rsp_tvalid/rsp_tready | tdata: value[63:0]
//
// Full and upper-half draws: 1 cycle per beat while the rsp register is free.
// Unit double: normalised by the leading-zero stepper (8 or 1 bit per cycle).
// Seed: loads both words with seed_value, then jumps via JumpMask and the shared state-step unit.
// Reset (synchronous) loads word zero with 1 and word one with 0; rsp empties.
// req_tready drops while an item is in work or a finished result waits on rsp.
`default_nettype none

module xoroshiro_random_generator (
   input  wire  logic                        clock,
   input  wire  logic                        reset,
   input  wire  logic                        req_tvalid,
   output logic                              req_tready,
   input  wire  logic [xrg_pkg::ReqWidth-1:0] req_tdata,   // operation, seed_value, zero pad
   output logic                              rsp_tvalid,
   input  wire  logic                        rsp_tready,
   output logic       [xrg_pkg::WordWidth-1:0] rsp_tdata    // value
);
   import xrg_pkg::*;

   state_type             state_ff, state_in;
   logic [WordWidth-1:0]  word0_ff, word0_in;
   logic [WordWidth-1:0]  word1_ff, word1_in;
   logic [WordWidth-1:0]  acc0_ff,  acc0_in;
   logic [WordWidth-1:0]  acc1_ff,  acc1_in;
   logic [CountWidth-1:0] cnt_ff,   cnt_in;
   logic [WordWidth-1:0]  res_ff,   res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0]  rsp_data_ff,  rsp_data_in;

   logic [WordWidth-1:0]  step_zero, step_one, step_draw;
   logic                  slot_free;
   logic                  accept;
   op_type                op;
   logic [WordWidth-1:0]  seed;
   norm_ctl_type          norm_ctl;
   norm_rsp_type          norm_rsp;

   xrg_step u_step (
      .word_zero (word0_ff),
      .word_one  (word1_ff),
      .next_zero (step_zero),
      .next_one  (step_one),
      .draw      (step_draw)
   );

   xrg_norm u_norm (
      .clock (clock),
      .reset (reset),
      .ctl   (norm_ctl),
      .rsp   (norm_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word0_ff     <= WordWidth'(1);
         word1_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word0_ff     <= word0_in;
         word1_ff     <= word1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc0_ff     <= acc0_in;
      acc1_ff     <= acc1_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tdata[1:0]);
   assign seed       = req_tdata[WordWidth+1:2];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      word0_in      = word0_ff;
      word1_in      = word1_ff;
      acc0_in       = acc0_ff;
      acc1_in       = acc1_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      norm_ctl.start = 1'b0;
      norm_ctl.mant  = step_draw[WordWidth-1:WordWidth-MantWidth];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_SEED: begin
                     word0_in = seed;
                     word1_in = seed;
                     acc0_in  = '0;
                     acc1_in  = '0;
                     cnt_in   = '0;
                     state_in = ST_JUMP;
                  end
                  OP_DRAW64: begin
                     word0_in     = step_zero;
                     word1_in     = step_one;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = step_draw;
                  end
                  OP_DRAW32: begin
                     word0_in     = step_zero;
                     word1_in     = step_one;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = {32'd0, step_draw[WordWidth-1:32]};
                  end
                  OP_DOUBLE: begin
                     word0_in       = step_zero;
                     word1_in       = step_one;
                     norm_ctl.start = 1'b1;
                     state_in       = ST_NORM;
                  end
                  default: ;
               endcase
            end
         end
         ST_JUMP: begin
            if (JumpMask[cnt_ff]) begin
               acc0_in = acc0_ff ^ word0_ff;
               acc1_in = acc1_ff ^ word1_ff;
            end
            if (cnt_ff == CountWidth'(JumpSteps - 1)) begin
               word0_in = acc0_in;
               word1_in = acc1_in;
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               word0_in = step_zero;
               word1_in = step_one;
               cnt_in   = cnt_ff + CountWidth'(1);
            end
         end
         ST_NORM: begin
            if (norm_rsp.done) begin
               res_in   = norm_rsp.bits;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/xrg_checker.sv
`default_nettype none
`include "xoroshiro_random_generator_assert.svh"

module xrg_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [xrg_pkg::ReqWidth-1:0]  req_tdata,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [xrg_pkg::WordWidth-1:0] rsp_tdata
);
   import xrg_pkg::*;

   // rsp beat holds while stalled
   `XRG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `XRG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // reset empties the output register
   `XRG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   // plain draws answer on the next cycle
   `XRG_ASSERT_NEXT(a_draw_next, clock, reset,
      req_tvalid && req_tready && (req_tdata[1:0] == OP_DRAW64 || req_tdata[1:0] == OP_DRAW32),
      rsp_tvalid)
   // a waiting result blocks new requests
   `XRG_ASSERT_NOW(a_no_accept_stalled, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

endmodule

bind xoroshiro_random_generator xrg_checker u_xrg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
